@@ sv/ecp3_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecp3_pkg
// Shared constants and types of the elastic pair collision pipeline.
// ----------------------------------------------------------------------------
package ecp3_pkg;

    localparam int NUM_AXES  = 3;
    // Lanes 0 to 2 hold the projection of A's velocity, lanes 3 to 5 that of B.
    localparam int NUM_LANES = 2 * NUM_AXES;

    typedef struct packed {
        logic valid;
        logic coincident;
    } t_flags;

endpackage

@@ sv/ecp3_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecp3_in_if / ecp3_out_if
// Valid/ready channels carrying one particle pair and one collision result.
// ----------------------------------------------------------------------------
interface ecp3_in_if #(parameter int VALUE_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] a_pos_x, a_pos_y, a_pos_z;
    logic signed [VALUE_WIDTH-1:0] a_vel_x, a_vel_y, a_vel_z;
    logic signed [VALUE_WIDTH-1:0] b_pos_x, b_pos_y, b_pos_z;
    logic signed [VALUE_WIDTH-1:0] b_vel_x, b_vel_y, b_vel_z;

    modport source (
        output valid, a_pos_x, a_pos_y, a_pos_z, a_vel_x, a_vel_y, a_vel_z,
               b_pos_x, b_pos_y, b_pos_z, b_vel_x, b_vel_y, b_vel_z,
        input  ready
    );
    modport sink (
        input  valid, a_pos_x, a_pos_y, a_pos_z, a_vel_x, a_vel_y, a_vel_z,
               b_pos_x, b_pos_y, b_pos_z, b_vel_x, b_vel_y, b_vel_z,
        output ready
    );
endinterface

interface ecp3_out_if #(parameter int VALUE_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] new_a_vel_x, new_a_vel_y, new_a_vel_z;
    logic signed [VALUE_WIDTH-1:0] new_b_vel_x, new_b_vel_y, new_b_vel_z;
    logic                          coincident;

    modport source (
        output valid, new_a_vel_x, new_a_vel_y, new_a_vel_z,
               new_b_vel_x, new_b_vel_y, new_b_vel_z, coincident,
        input  ready
    );
    modport sink (
        input  valid, new_a_vel_x, new_a_vel_y, new_a_vel_z,
               new_b_vel_x, new_b_vel_y, new_b_vel_z, coincident,
        output ready
    );
endinterface

@@ sv/ecp3_dot.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecp3_dot
// Three stages: separation vector, per-axis products, and the dot products
// d.d, vA.d and vB.d.
// ----------------------------------------------------------------------------
module ecp3_dot import ecp3_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [VALUE_WIDTH-1:0]   i_pa [NUM_AXES],
    input  logic signed [VALUE_WIDTH-1:0]   i_pb [NUM_AXES],
    input  logic signed [VALUE_WIDTH-1:0]   i_va [NUM_AXES],
    input  logic signed [VALUE_WIDTH-1:0]   i_vb [NUM_AXES],
    output t_flags                          o_flags,
    output logic [2*VALUE_WIDTH+1:0]        o_q,
    output logic signed [2*VALUE_WIDTH+2:0] o_sa,
    output logic signed [2*VALUE_WIDTH+2:0] o_sb,
    output logic signed [VALUE_WIDTH:0]     o_d  [NUM_AXES],
    output logic signed [VALUE_WIDTH-1:0]   o_va [NUM_AXES],
    output logic signed [VALUE_WIDTH-1:0]   o_vb [NUM_AXES]
);
    localparam int W   = VALUE_WIDTH;
    localparam int DW  = W + 1;
    localparam int QW  = 2 * W + 2;
    localparam int PVW = W + DW;
    localparam int SW  = 2 * W + 3;

    t_flags                r1_flags, r2_flags, r3_flags;
    logic signed [DW-1:0]  r1_d  [NUM_AXES];
    logic signed [DW-1:0]  r2_d  [NUM_AXES];
    logic signed [DW-1:0]  r3_d  [NUM_AXES];
    logic signed [W-1:0]   r1_va [NUM_AXES];
    logic signed [W-1:0]   r1_vb [NUM_AXES];
    logic signed [W-1:0]   r2_va [NUM_AXES];
    logic signed [W-1:0]   r2_vb [NUM_AXES];
    logic signed [W-1:0]   r3_va [NUM_AXES];
    logic signed [W-1:0]   r3_vb [NUM_AXES];
    logic signed [QW-1:0]  r2_dd [NUM_AXES];
    logic signed [PVW-1:0] r2_ad [NUM_AXES];
    logic signed [PVW-1:0] r2_bd [NUM_AXES];
    logic [QW-1:0]         r3_q;
    logic signed [SW-1:0]  r3_sa, r3_sb;

    logic                  n1_zero;
    logic signed [DW-1:0]  n1_d [NUM_AXES];

    always_comb begin
        n1_zero = 1'b1;
        for (int i = 0; i < NUM_AXES; i++) begin
            n1_d[i] = DW'(i_pb[i]) - DW'(i_pa[i]);
            if (i_pa[i] != i_pb[i]) begin
                n1_zero = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_flags <= '0;
            r2_flags <= '0;
            r3_flags <= '0;
        end else if (i_en) begin
            r1_flags <= '{valid: i_valid, coincident: n1_zero};
            r2_flags <= r1_flags;
            r3_flags <= r2_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r1_d[i]  <= n1_d[i];
                r1_va[i] <= i_va[i];
                r1_vb[i] <= i_vb[i];
                r2_dd[i] <= QW'(r1_d[i]) * QW'(r1_d[i]);
                r2_ad[i] <= PVW'(r1_va[i]) * PVW'(r1_d[i]);
                r2_bd[i] <= PVW'(r1_vb[i]) * PVW'(r1_d[i]);
                r2_d[i]  <= r1_d[i];
                r2_va[i] <= r1_va[i];
                r2_vb[i] <= r1_vb[i];
                r3_d[i]  <= r2_d[i];
                r3_va[i] <= r2_va[i];
                r3_vb[i] <= r2_vb[i];
            end
            // Squares are never negative and their sum stays below 2^QW.
            r3_q  <= $unsigned(r2_dd[0]) + $unsigned(r2_dd[1]) + $unsigned(r2_dd[2]);
            r3_sa <= SW'(r2_ad[0]) + SW'(r2_ad[1]) + SW'(r2_ad[2]);
            r3_sb <= SW'(r2_bd[0]) + SW'(r2_bd[1]) + SW'(r2_bd[2]);
        end
    end

    assign o_flags = r3_flags;
    assign o_q     = r3_q;
    assign o_sa    = r3_sa;
    assign o_sb    = r3_sb;
    assign o_d     = r3_d;
    assign o_va    = r3_va;
    assign o_vb    = r3_vb;

endmodule

@@ sv/ecp3_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecp3_scale
// Three stages forming the dividend |s * d_i| of each projection lane, with
// the wide product split into two partial products.
// ----------------------------------------------------------------------------
module ecp3_scale import ecp3_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  t_flags                          i_flags,
    input  logic [2*VALUE_WIDTH+1:0]        i_q,
    input  logic signed [2*VALUE_WIDTH+2:0] i_sa,
    input  logic signed [2*VALUE_WIDTH+2:0] i_sb,
    input  logic signed [VALUE_WIDTH:0]     i_d  [NUM_AXES],
    input  logic signed [VALUE_WIDTH-1:0]   i_va [NUM_AXES],
    input  logic signed [VALUE_WIDTH-1:0]   i_vb [NUM_AXES],
    output t_flags                          o_flags,
    output logic [2*VALUE_WIDTH+1:0]        o_q,
    output logic [3*VALUE_WIDTH+1:0]        o_num [NUM_LANES],
    output logic                            o_neg [NUM_LANES],
    output logic signed [VALUE_WIDTH-1:0]   o_va  [NUM_AXES],
    output logic signed [VALUE_WIDTH-1:0]   o_vb  [NUM_AXES]
);
    localparam int W   = VALUE_WIDTH;
    localparam int QW  = 2 * W + 2;
    localparam int MW  = 2 * W + 1;
    localparam int DMW = W + 1;
    localparam int NW  = MW + DMW;
    localparam int SPL = (MW + 1) / 2;
    localparam int HIW = MW - SPL;

    t_flags                r4_flags, r5_flags, r6_flags;
    logic [QW-1:0]         r4_q, r5_q, r6_q;
    logic [MW-1:0]         r4_smag [2];
    logic [DMW-1:0]        r4_dmag [NUM_AXES];
    logic                  r4_neg [NUM_LANES];
    logic                  r5_neg [NUM_LANES];
    logic                  r6_neg [NUM_LANES];
    logic [SPL+DMW-1:0]    r5_lo  [NUM_LANES];
    logic [HIW+DMW-1:0]    r5_hi  [NUM_LANES];
    logic [NW-1:0]         r6_num [NUM_LANES];
    logic signed [W-1:0]   r4_va [NUM_AXES];
    logic signed [W-1:0]   r4_vb [NUM_AXES];
    logic signed [W-1:0]   r5_va [NUM_AXES];
    logic signed [W-1:0]   r5_vb [NUM_AXES];
    logic signed [W-1:0]   r6_va [NUM_AXES];
    logic signed [W-1:0]   r6_vb [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_flags <= '0;
            r5_flags <= '0;
            r6_flags <= '0;
        end else if (i_en) begin
            r4_flags <= i_flags;
            r5_flags <= r4_flags;
            r6_flags <= r5_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_q <= i_q;
            r5_q <= r4_q;
            r6_q <= r5_q;
            r4_smag[0] <= MW'(i_sa < 0 ? -i_sa : i_sa);
            r4_smag[1] <= MW'(i_sb < 0 ? -i_sb : i_sb);
            for (int i = 0; i < NUM_AXES; i++) begin
                r4_dmag[i] <= DMW'(i_d[i] < 0 ? -i_d[i] : i_d[i]);
                r4_neg[i]            <= i_sa[2*W+2] ^ i_d[i][W];
                r4_neg[NUM_AXES + i] <= i_sb[2*W+2] ^ i_d[i][W];
                r4_va[i] <= i_va[i];
                r4_vb[i] <= i_vb[i];
                r5_va[i] <= r4_va[i];
                r5_vb[i] <= r4_vb[i];
                r6_va[i] <= r5_va[i];
                r6_vb[i] <= r5_vb[i];
            end
            for (int l = 0; l < NUM_LANES; l++) begin
                r5_lo[l]  <= (SPL+DMW)'(r4_smag[l / NUM_AXES][SPL-1:0])
                           * (SPL+DMW)'(r4_dmag[l % NUM_AXES]);
                r5_hi[l]  <= (HIW+DMW)'(r4_smag[l / NUM_AXES][MW-1:SPL])
                           * (HIW+DMW)'(r4_dmag[l % NUM_AXES]);
                r5_neg[l] <= r4_neg[l];
                r6_num[l] <= (NW'(r5_hi[l]) << SPL) + NW'(r5_lo[l]);
                r6_neg[l] <= r5_neg[l];
            end
        end
    end

    assign o_flags = r6_flags;
    assign o_q     = r6_q;
    assign o_num   = r6_num;
    assign o_neg   = r6_neg;
    assign o_va    = r6_va;
    assign o_vb    = r6_vb;

endmodule

@@ sv/ecp3_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecp3_div
// Pipelined restoring divider for all projection lanes: one quotient bit per
// stage, sharing the divisor d.d.
// ----------------------------------------------------------------------------
module ecp3_div import ecp3_pkg::*; #(
    parameter int VALUE_WIDTH = 32,
    parameter int SIDE_W      = 192
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  t_flags                     i_flags,
    input  logic [2*VALUE_WIDTH+1:0]   i_q,
    input  logic [3*VALUE_WIDTH+1:0]   i_num [NUM_LANES],
    input  logic                       i_neg [NUM_LANES],
    input  logic [SIDE_W-1:0]          i_side,
    output t_flags                     o_flags,
    output logic [2*VALUE_WIDTH+1:0]   o_q,
    output logic [VALUE_WIDTH:0]       o_quo [NUM_LANES],
    output logic [2*VALUE_WIDTH+1:0]   o_rem [NUM_LANES],
    output logic                       o_neg [NUM_LANES],
    output logic [SIDE_W-1:0]          o_side
);
    localparam int W  = VALUE_WIDTH;
    localparam int QW = 2 * W + 2;
    localparam int NW = 3 * W + 2;
    // |projection| never exceeds |v|, so W + 1 quotient bits cover it.
    localparam int QB = W + 1;

    t_flags             r_flags [QB];
    logic [QW-1:0]      r_q     [QB];
    logic [SIDE_W-1:0]  r_side  [QB];
    logic [QW-1:0]      r_rem   [QB][NUM_LANES];
    logic [QB-1:0]      r_low   [QB][NUM_LANES];
    logic [QB-1:0]      r_quo   [QB][NUM_LANES];
    logic               r_neg   [QB][NUM_LANES];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        t_flags            p_flags;
        logic [QW-1:0]     p_q;
        logic [SIDE_W-1:0] p_side;
        logic [QW-1:0]     p_rem [NUM_LANES];
        logic [QB-1:0]     p_low [NUM_LANES];
        logic [QB-1:0]     p_quo [NUM_LANES];
        logic              p_neg [NUM_LANES];
        logic [QW-1:0]     n_rem [NUM_LANES];
        logic              n_bit [NUM_LANES];

        if (k == 0) begin : g_load
            always_comb begin
                p_flags = i_flags;
                p_q     = i_q;
                p_side  = i_side;
                for (int l = 0; l < NUM_LANES; l++) begin
                    p_rem[l] = QW'(i_num[l][NW-1:QB]);
                    p_low[l] = i_num[l][QB-1:0];
                    p_quo[l] = '0;
                    p_neg[l] = i_neg[l];
                end
            end
        end else begin : g_chain
            always_comb begin
                p_flags = r_flags[k-1];
                p_q     = r_q[k-1];
                p_side  = r_side[k-1];
                for (int l = 0; l < NUM_LANES; l++) begin
                    p_rem[l] = r_rem[k-1][l];
                    p_low[l] = r_low[k-1][l];
                    p_quo[l] = r_quo[k-1][l];
                    p_neg[l] = r_neg[k-1][l];
                end
            end
        end

        always_comb begin
            logic [QW:0] t;
            for (int l = 0; l < NUM_LANES; l++) begin
                t        = {p_rem[l], p_low[l][QB-1]};
                n_bit[l] = (t >= {1'b0, p_q});
                n_rem[l] = n_bit[l] ? QW'(t - {1'b0, p_q}) : QW'(t);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_flags[k] <= '0;
            end else if (i_en) begin
                r_flags[k] <= p_flags;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]    <= p_q;
                r_side[k] <= p_side;
                for (int l = 0; l < NUM_LANES; l++) begin
                    r_rem[k][l] <= n_rem[l];
                    r_low[k][l] <= p_low[l] << 1;
                    r_quo[k][l] <= {p_quo[l][QB-2:0], n_bit[l]};
                    r_neg[k][l] <= p_neg[l];
                end
            end
        end
    end

    assign o_flags = r_flags[QB-1];
    assign o_q     = r_q[QB-1];
    assign o_side  = r_side[QB-1];
    assign o_quo   = r_quo[QB-1];
    assign o_rem   = r_rem[QB-1];
    assign o_neg   = r_neg[QB-1];

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_chk
        // The quotient must fit in QB bits, so the leading dividend bits
        // stay below the divisor.
        a_head_below_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            i_en && i_flags.valid && !i_flags.coincident
            |-> QW'(i_num[l][NW-1:QB]) < i_q)
            else $error("dividend head not below divisor");

        a_rem_below_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            o_flags.valid && !o_flags.coincident |-> o_rem[l] < o_q)
            else $error("final remainder not below divisor");
    end

    a_q_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_flags.valid && !o_flags.coincident |-> o_q != '0)
        else $error("zero divisor on a non-coincident item");

endmodule

@@ sv/elastic_pair_collision_3d_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elastic_pair_collision_3d_core
// Equal-mass elastic collision of two particles in three dimensions.
// ----------------------------------------------------------------------------
// Items arrive on i_in, one particle pair each (positions and velocities of A
// and B in signed fixed point). Each item gives one result on o_out: both new
// velocities, saturated to the value range, and a coincident flag that is set,
// with the velocities passed through, when the two positions are equal.
// Both channels use valid/ready; an item moves when both are high.
// The pipeline holds three stages for the dot products, three for the scaled
// dividends, VALUE_WIDTH + 1 stages of the restoring divider at one quotient
// bit each, one rounding stage and the output register. One item is accepted
// in every cycle unless the output register holds a result that is not taken.
// The whole pipeline advances together; when the output register holds a
// result that is not taken, every stage holds and i_in.ready falls, so no
// item is lost or repeated. A synchronous reset empties the pipeline at once,
// and i_in.ready stays low while reset is held.
// ----------------------------------------------------------------------------
module elastic_pair_collision_3d_core import ecp3_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ecp3_in_if.sink     i_in,
    ecp3_out_if.source  o_out
);
    localparam int W      = VALUE_WIDTH;
    localparam int QW     = 2 * W + 2;
    localparam int NW     = 3 * W + 2;
    localparam int QB     = W + 1;
    localparam int PW     = W + 3;
    localparam int SUMW   = W + 5;
    localparam int SIDE_W = NUM_LANES * W;

    logic                  w_en;
    logic signed [W-1:0]   w_pa [NUM_AXES];
    logic signed [W-1:0]   w_pb [NUM_AXES];
    logic signed [W-1:0]   w_va [NUM_AXES];
    logic signed [W-1:0]   w_vb [NUM_AXES];

    t_flags                d_flags;
    logic [QW-1:0]         d_q;
    logic signed [2*W+2:0] d_sa, d_sb;
    logic signed [W:0]     d_d  [NUM_AXES];
    logic signed [W-1:0]   d_va [NUM_AXES];
    logic signed [W-1:0]   d_vb [NUM_AXES];

    t_flags                s_flags;
    logic [QW-1:0]         s_q;
    logic [NW-1:0]         s_num [NUM_LANES];
    logic                  s_neg [NUM_LANES];
    logic signed [W-1:0]   s_va  [NUM_AXES];
    logic signed [W-1:0]   s_vb  [NUM_AXES];
    logic [SIDE_W-1:0]     s_side;

    t_flags                v_flags;
    logic [QW-1:0]         v_q;
    logic [QB-1:0]         v_quo [NUM_LANES];
    logic [QW-1:0]         v_rem [NUM_LANES];
    logic                  v_neg [NUM_LANES];
    logic [SIDE_W-1:0]     v_side;

    t_flags                r_rnd_flags, r_out_flags;
    logic signed [PW-1:0]  r_proj [NUM_LANES];
    logic [SIDE_W-1:0]     r_rnd_side;
    logic signed [W-1:0]   r_out_va [NUM_AXES];
    logic signed [W-1:0]   r_out_vb [NUM_AXES];

    logic signed [PW-1:0]  n_proj [NUM_LANES];
    logic signed [W-1:0]   n_out_va [NUM_AXES];
    logic signed [W-1:0]   n_out_vb [NUM_AXES];

    assign w_en       = !r_out_flags.valid || o_out.ready;
    assign i_in.ready = i_rst_n && w_en;

    assign w_pa = '{i_in.a_pos_x, i_in.a_pos_y, i_in.a_pos_z};
    assign w_pb = '{i_in.b_pos_x, i_in.b_pos_y, i_in.b_pos_z};
    assign w_va = '{i_in.a_vel_x, i_in.a_vel_y, i_in.a_vel_z};
    assign w_vb = '{i_in.b_vel_x, i_in.b_vel_y, i_in.b_vel_z};

    ecp3_dot #(.VALUE_WIDTH(W)) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_pa    (w_pa),
        .i_pb    (w_pb),
        .i_va    (w_va),
        .i_vb    (w_vb),
        .o_flags (d_flags),
        .o_q     (d_q),
        .o_sa    (d_sa),
        .o_sb    (d_sb),
        .o_d     (d_d),
        .o_va    (d_va),
        .o_vb    (d_vb)
    );

    ecp3_scale #(.VALUE_WIDTH(W)) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_flags (d_flags),
        .i_q     (d_q),
        .i_sa    (d_sa),
        .i_sb    (d_sb),
        .i_d     (d_d),
        .i_va    (d_va),
        .i_vb    (d_vb),
        .o_flags (s_flags),
        .o_q     (s_q),
        .o_num   (s_num),
        .o_neg   (s_neg),
        .o_va    (s_va),
        .o_vb    (s_vb)
    );

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            s_side[i*W +: W]            = s_va[i];
            s_side[(NUM_AXES+i)*W +: W] = s_vb[i];
        end
    end

    ecp3_div #(.VALUE_WIDTH(W), .SIDE_W(SIDE_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_flags (s_flags),
        .i_q     (s_q),
        .i_num   (s_num),
        .i_neg   (s_neg),
        .i_side  (s_side),
        .o_flags (v_flags),
        .o_q     (v_q),
        .o_quo   (v_quo),
        .o_rem   (v_rem),
        .o_neg   (v_neg),
        .o_side  (v_side)
    );

    // Round to nearest, ties away from zero, on the magnitude; then sign it.
    always_comb begin
        logic [W+1:0] mag;
        for (int l = 0; l < NUM_LANES; l++) begin
            mag       = (W+2)'(v_quo[l])
                      + (W+2)'({v_rem[l], 1'b0} >= {1'b0, v_q});
            n_proj[l] = v_neg[l] ? -PW'(mag) : PW'(mag);
        end
    end

    // Exchange the along-line parts and clamp to the value range; a coincident pair passes through.
    always_comb begin
        logic signed [SUMW-1:0] sum_a, sum_b;
        logic signed [W-1:0]    va, vb;
        for (int i = 0; i < NUM_AXES; i++) begin
            va    = r_rnd_side[i*W +: W];
            vb    = r_rnd_side[(NUM_AXES+i)*W +: W];
            sum_a = SUMW'(va) - SUMW'(r_proj[i]) + SUMW'(r_proj[NUM_AXES+i]);
            sum_b = SUMW'(vb) - SUMW'(r_proj[NUM_AXES+i]) + SUMW'(r_proj[i]);
            if (r_rnd_flags.coincident) begin
                n_out_va[i] = va;
                n_out_vb[i] = vb;
            end else begin
                if (sum_a[SUMW-1:W-1] != {(SUMW-W+1){sum_a[SUMW-1]}}) begin
                    n_out_va[i] = {sum_a[SUMW-1], {(W-1){!sum_a[SUMW-1]}}};
                end else begin
                    n_out_va[i] = sum_a[W-1:0];
                end
                if (sum_b[SUMW-1:W-1] != {(SUMW-W+1){sum_b[SUMW-1]}}) begin
                    n_out_vb[i] = {sum_b[SUMW-1], {(W-1){!sum_b[SUMW-1]}}};
                end else begin
                    n_out_vb[i] = sum_b[W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_flags <= '0;
            r_out_flags <= '0;
        end else if (w_en) begin
            r_rnd_flags <= v_flags;
            r_out_flags <= r_rnd_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_proj     <= n_proj;
            r_rnd_side <= v_side;
            r_out_va   <= n_out_va;
            r_out_vb   <= n_out_vb;
        end
    end

    assign o_out.valid       = r_out_flags.valid;
    assign o_out.coincident  = r_out_flags.coincident;
    assign o_out.new_a_vel_x = r_out_va[0];
    assign o_out.new_a_vel_y = r_out_va[1];
    assign o_out.new_a_vel_z = r_out_va[2];
    assign o_out.new_b_vel_x = r_out_vb[0];
    assign o_out.new_b_vel_y = r_out_vb[1];
    assign o_out.new_b_vel_z = r_out_vb[2];

    localparam logic signed [PW-1:0] PROJ_LIM = PW'(1) <<< W;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_chk
        // A projection is never longer than the velocity it came from, and
        // that velocity is at most sqrt(3) times the largest component.
        a_proj_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_rnd_flags.valid && !r_rnd_flags.coincident
            |-> r_proj[l] <= PROJ_LIM && r_proj[l] >= -PROJ_LIM)
            else $error("projection exceeds the value range");
    end

    a_rnd_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rnd_flags.valid && w_en |=> o_out.valid)
        else $error("item lost between rounding and output stages");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid straight after reset");

endmodule

@@ tb/elastic_pair_collision_3d_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elastic_pair_collision_3d_core_tb
// Self-checking bench for the equal-mass elastic pair collision core.
// ----------------------------------------------------------------------------
// Particle pairs are sent on the input channel in bursts with random gaps,
// while the result channel stalls on a changing pattern. Each accepted pair is
// run through an exact wide-integer collision predictor, and every result is
// compared field by field, in order, with the oldest prediction. Directed pairs
// cover the range extremes, coincident positions and saturation; random pairs
// mix full-range, small and near-coincident values.
// ----------------------------------------------------------------------------
module elastic_pair_collision_3d_core_tb;
    import ecp3_pkg::*;

    localparam int VW = 32;

    typedef logic signed [191:0] t_wide;

    typedef struct {
        logic signed [VW-1:0] ap[3];
        logic signed [VW-1:0] av[3];
        logic signed [VW-1:0] bp[3];
        logic signed [VW-1:0] bv[3];
    } t_pair;

    typedef struct {
        logic signed [VW-1:0] na[3];
        logic signed [VW-1:0] nb[3];
        logic                 coincident;
    } t_velocities;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ecp3_in_if  #(.VALUE_WIDTH(VW)) in_if ();
    ecp3_out_if #(.VALUE_WIDTH(VW)) out_if ();

    elastic_pair_collision_3d_core #(.VALUE_WIDTH(VW)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_velocities expected_vels[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          pairs_sent = 0;
    int          coincident_seen = 0;
    bit          sink_enable = 1'b0;

    initial begin
        in_if.valid   = 1'b0;
        in_if.a_pos_x = '0; in_if.a_pos_y = '0; in_if.a_pos_z = '0;
        in_if.a_vel_x = '0; in_if.a_vel_y = '0; in_if.a_vel_z = '0;
        in_if.b_pos_x = '0; in_if.b_pos_y = '0; in_if.b_pos_z = '0;
        in_if.b_vel_x = '0; in_if.b_vel_y = '0; in_if.b_vel_z = '0;
        out_if.ready  = 1'b0;
    end

    // Exact quotient rounded to nearest, ties away from zero; q is positive.
    function automatic t_wide round_div(t_wide n, t_wide q);
        t_wide mag, quo, rem;
        bit    neg;
        neg = n < 0;
        mag = neg ? -n : n;
        quo = mag / q;
        rem = mag - quo * q;
        if ((rem <<< 1) >= q) quo = quo + 1;
        return neg ? -quo : quo;
    endfunction

    function automatic logic signed [VW-1:0] clamp_value(t_wide x);
        t_wide hi, lo;
        hi = (t_wide'(1) <<< (VW - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) x = hi;
        if (x < lo) x = lo;
        return x[VW-1:0];
    endfunction

    function automatic t_velocities collide(t_pair p);
        t_velocities r;
        t_wide       d[3], va[3], vb[3];
        t_wide       dd, sa, sb, proj_a, proj_b;
        bit          same;
        same = 1'b1;
        for (int i = 0; i < 3; i++) begin
            d[i]  = t_wide'(p.bp[i]) - t_wide'(p.ap[i]);
            va[i] = p.av[i];
            vb[i] = p.bv[i];
            if (d[i] != 0) same = 1'b0;
        end
        r.coincident = same;
        if (same) begin
            for (int i = 0; i < 3; i++) begin
                r.na[i] = p.av[i];
                r.nb[i] = p.bv[i];
            end
        end else begin
            dd = 0; sa = 0; sb = 0;
            for (int i = 0; i < 3; i++) begin
                dd = dd + d[i] * d[i];
                sa = sa + va[i] * d[i];
                sb = sb + vb[i] * d[i];
            end
            for (int i = 0; i < 3; i++) begin
                proj_a = round_div(sa * d[i], dd);
                proj_b = round_div(sb * d[i], dd);
                r.na[i] = clamp_value(va[i] - proj_a + proj_b);
                r.nb[i] = clamp_value(vb[i] - proj_b + proj_a);
            end
        end
        return r;
    endfunction

    // Leaves valid high so that a burst runs on without a gap.
    task automatic send_pair(t_pair p);
        in_if.valid   <= 1'b1;
        in_if.a_pos_x <= p.ap[0]; in_if.a_pos_y <= p.ap[1]; in_if.a_pos_z <= p.ap[2];
        in_if.a_vel_x <= p.av[0]; in_if.a_vel_y <= p.av[1]; in_if.a_vel_z <= p.av[2];
        in_if.b_pos_x <= p.bp[0]; in_if.b_pos_y <= p.bp[1]; in_if.b_pos_z <= p.bp[2];
        in_if.b_vel_x <= p.bv[0]; in_if.b_vel_y <= p.bv[1]; in_if.b_vel_z <= p.bv[2];
        do @(posedge i_clk); while (!in_if.ready);
        expected_vels.push_back(collide(p));
        pairs_sent++;
    endtask

    task automatic idle_cycles(int n);
        if (n > 0) begin
            in_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [VW-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            1:       return $signed($urandom_range(0, 2000)) - 1000;
            2:       return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        int    shape;
        shape = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            p.ap[i] = pick_value();
            p.av[i] = pick_value();
            p.bv[i] = pick_value();
            // Mostly nearby partners; sometimes far, sometimes coincident.
            if (shape == 0)
                p.bp[i] = p.ap[i];
            else if (shape < 7)
                p.bp[i] = p.ap[i] + ($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
            else
                p.bp[i] = pick_value();
        end
        if (shape == 1) p.bp[$urandom_range(0, 2)] = p.ap[0] + 1;
        return p;
    endfunction

    function automatic t_pair uniform_pair(logic signed [VW-1:0] pos_a,
                                           logic signed [VW-1:0] pos_b,
                                           logic signed [VW-1:0] vel_a,
                                           logic signed [VW-1:0] vel_b);
        t_pair p;
        for (int i = 0; i < 3; i++) begin
            p.ap[i] = pos_a; p.bp[i] = pos_b;
            p.av[i] = vel_a; p.bv[i] = vel_b;
        end
        return p;
    endfunction

    // Result checker: compares each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            t_velocities want;
            bit          bad;
            results_seen++;
            if (out_if.coincident) coincident_seen++;
            if (expected_vels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: result with no pair outstanding");
            end else begin
                want = expected_vels.pop_front();
                bad = (out_if.new_a_vel_x !== want.na[0]) || (out_if.new_a_vel_y !== want.na[1])
                   || (out_if.new_a_vel_z !== want.na[2]) || (out_if.new_b_vel_x !== want.nb[0])
                   || (out_if.new_b_vel_y !== want.nb[1]) || (out_if.new_b_vel_z !== want.nb[2])
                   || (out_if.coincident !== want.coincident);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: result %0d: expected A %h %h %h B %h %h %h c %b, ",
                                  "got A %h %h %h B %h %h %h c %b"}, results_seen,
                                 want.na[0], want.na[1], want.na[2],
                                 want.nb[0], want.nb[1], want.nb[2], want.coincident,
                                 out_if.new_a_vel_x, out_if.new_a_vel_y, out_if.new_a_vel_z,
                                 out_if.new_b_vel_x, out_if.new_b_vel_y, out_if.new_b_vel_z,
                                 out_if.coincident);
                end
            end
        end
    end

    // Receiver stalls: the pattern changes every so often between always
    // ready, random ready and long stretches of back-pressure.
    int stall_mode = 0;
    int stall_left = 0;
    int pattern_left = 0;
    always @(posedge i_clk) begin
        if (pattern_left == 0) begin
            stall_mode   <= $urandom_range(0, 2);
            pattern_left <= $urandom_range(32, 300);
        end else begin
            pattern_left <= pattern_left - 1;
        end
        if (!sink_enable) begin
            out_if.ready <= 1'b0;
        end else if (stall_mode == 0) begin
            out_if.ready <= 1'b1;
        end else if (stall_mode == 1) begin
            out_if.ready <= $urandom_range(0, 1);
        end else if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            out_if.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 20);
        end
    end

    task automatic test_directed();
        t_pair p;
        send_pair(uniform_pair(0, 0, 32'sh0001_0000, -32'sh0001_0000));
        send_pair(uniform_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
        idle_cycles(3);
        send_pair(uniform_pair(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));
        send_pair(uniform_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
        send_pair(uniform_pair(0, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_pair(uniform_pair(0, -1, 32'sh8000_0000, 0));
        send_pair(uniform_pair(-1, 0, -1, -1));
        send_pair(uniform_pair(32'sh1234_5678, 32'sh1234_5679, 32'sh0003_0000, 0));
        // Separation along one axis only: a head-on swap of that component.
        p = uniform_pair(0, 0, 32'sh0002_0000, -32'sh0001_0000);
        p.bp[0] = 32'sh0001_0000;
        send_pair(p);
        p.bp[0] = 0; p.bp[2] = 32'sh8000_0000; p.ap[2] = 32'sh7FFF_FFFF;
        send_pair(p);
        // Glancing contact with saturating velocities on different axes.
        p = uniform_pair(0, 0, 0, 0);
        p.bp[0] = 3; p.bp[1] = -2; p.bp[2] = 1;
        p.av[0] = 32'sh7FFF_FFFF; p.av[1] = 32'sh8000_0000; p.av[2] = 5;
        p.bv[0] = 32'sh8000_0000; p.bv[1] = 32'sh7FFF_FFFF; p.bv[2] = -7;
        send_pair(p);
        p.bp[0] = 1; p.bp[1] = 1; p.bp[2] = 0; p.av[0] = 1; p.av[1] = 0; p.bv[0] = 0;
        send_pair(p); // half-unit projections round away from zero
        p.av[0] = -1;
        send_pair(p);
        idle_cycles(1);
    endtask

    task automatic test_random(int count);
        int left, burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left) burst = left;
            repeat (burst) send_pair(random_pair());
            left -= burst;
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
        end
        idle_cycles(1);
    endtask

    // The sender holds off until the pipeline has drained completely.
    task automatic test_drain_pause();
        in_if.valid <= 1'b0;
        while (expected_vels.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        test_random(60);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        sink_enable <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(600);
        test_drain_pause();
        test_random(600);
        while (expected_vels.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Covered %0d particle pairs (%0d coincident) under bursty input and stalls.",
                 pairs_sent, coincident_seen);
        $display("Results checked: %0d, mismatches: %0d.", results_seen, mismatches);
        if (mismatches == 0 && expected_vels.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("Timeout with %0d results outstanding.", expected_vels.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
sv/ecp3_pkg.sv
sv/ecp3_if.sv
sv/ecp3_dot.sv
sv/ecp3_scale.sv
sv/ecp3_div.sv
sv/elastic_pair_collision_3d_core.sv
tb/elastic_pair_collision_3d_core_tb.sv
